>>> sv/csvfw_pkg.sv
// csvfw_pkg: shared types and constants for the CSV field writer.
// Word formats, command and register codes, job descriptor, buffer write port.
// No dependencies.
package csvfw_pkg;

    localparam int CNT_W   = 5;   // fill count / index width, holds up to 31
    localparam int Q_DEPTH = 2;   // front-to-back job queue depth

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // command codes
    localparam logic [1:0] CMD_QBYTE = 2'd0;
    localparam logic [1:0] CMD_RAW   = 2'd1;
    localparam logic [1:0] CMD_EOL   = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_SEP   = 2'd0;
    localparam logic [1:0] CFG_QUOTE = 2'd1;
    localparam logic [1:0] CFG_TRIM  = 2'd2;
    localparam logic [1:0] CFG_CRLF  = 2'd3;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_BYTE,
        BODY_EOL,
        BODY_DUMP
    } body_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       field_last;
        logic       field_empty;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       overflow;
    } result_t;

    // one queued unit of output work
    typedef struct packed {
        logic             sep;
        logic [7:0]       sep_char;
        body_t            body;
        logic [7:0]       data;
        logic             crlf;
        logic             quote;
        logic [7:0]       quote_char;
        logic [CNT_W-1:0] count;
        logic             ov;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

endpackage

>>> sv/csvfw_front.sv
// csvfw_front: accepts commands, tracks field/row state and configuration,
// writes field bytes to the buffer and issues jobs to the queue.
// Depends on csvfw_pkg.
module csvfw_front
    import csvfw_pkg::*;
#(
    parameter int MAX_FIELD = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    output logic       busy,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       push,
    output job_t       job,
    input  logic       q_full,
    input  logic       dump_done,
    output mem_wr_t    mem_wr
);

    logic [7:0]       sep_char_reg, quote_char_reg;
    logic             trim_reg, crlf_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             row_start_reg, row_start_next;
    logic             inside_reg, inside_next;
    logic             qneed_reg, qneed_next;
    logic             dropped_reg, dropped_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       last_reg, last_next;
    logic             lock_reg, lock_next;

    logic             accept;
    logic             closing;
    logic [7:0]       b;
    body_t            body;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    assign busy    = q_full | lock_reg;
    assign accept  = start & ~busy;
    assign closing = item.field_last | item.field_empty;
    assign b       = item.data_byte;

    always_comb
    begin
        fill_next      = fill_reg;
        row_start_next = row_start_reg;
        inside_next    = inside_reg;
        qneed_next     = qneed_reg;
        dropped_next   = dropped_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        mem_wr         = '0;
        body           = BODY_NONE;
        job            = '0;
        job.sep_char   = sep_char_reg;
        job.quote_char = quote_char_reg;
        job.crlf       = crlf_reg;
        job.data       = b;
        push           = 1'b0;
        if (accept)
        begin
            case (item.cmd)
                CMD_EOL:
                begin
                    fill_next      = '0;
                    qneed_next     = 1'b0;
                    dropped_next   = 1'b0;
                    inside_next    = 1'b0;
                    row_start_next = 1'b1;
                    body           = BODY_EOL;
                end
                CMD_QBYTE, CMD_RAW:
                begin
                    if (!inside_reg)
                    begin
                        // opening a new field
                        job.sep        = ~row_start_reg;
                        row_start_next = 1'b0;
                        fill_next      = '0;
                        qneed_next     = 1'b0;
                        dropped_next   = 1'b0;
                    end
                    inside_next = 1'b1;
                    if (item.cmd == CMD_QBYTE)
                    begin
                        if (!item.field_empty)
                        begin
                            if (fill_next < CNT_W'(MAX_FIELD))
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = fill_next;
                                mem_wr.data = b;
                                if (fill_next == '0)
                                begin
                                    first_next = b;
                                end
                                last_next = b;
                                fill_next = fill_next + CNT_W'(1);
                                if (b == sep_char_reg || b == quote_char_reg ||
                                    b == CH_CR || b == CH_LF)
                                begin
                                    qneed_next = 1'b1;
                                end
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        job.ov = dropped_next;
                        if (closing)
                        begin
                            job.quote = qneed_next |
                                (trim_reg && fill_next != '0 &&
                                 (is_blank(first_next) || is_blank(last_next)));
                            job.count = fill_next;
                            if (fill_next != '0)
                            begin
                                body = BODY_DUMP;
                            end
                        end
                    end
                    else if (!item.field_empty)
                    begin
                        body = BODY_BYTE;
                    end
                    if (closing)
                    begin
                        fill_next    = '0;
                        qneed_next   = 1'b0;
                        dropped_next = 1'b0;
                        inside_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            job.body = body;
            push     = job.sep || (body != BODY_NONE);
        end
    end

    // buffer stays owned by the back end until it has written the field out
    always_comb
    begin
        lock_next = lock_reg;
        if (push && body == BODY_DUMP)
        begin
            lock_next = 1'b1;
        end
        else if (dump_done)
        begin
            lock_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_char_reg   <= SEP_RESET;
            quote_char_reg <= QUOTE_RESET;
            trim_reg       <= 1'b0;
            crlf_reg       <= 1'b0;
            fill_reg       <= '0;
            row_start_reg  <= 1'b1;
            inside_reg     <= 1'b0;
            qneed_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            lock_reg       <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            row_start_reg <= row_start_next;
            inside_reg    <= inside_next;
            qneed_reg     <= qneed_next;
            dropped_reg   <= dropped_next;
            lock_reg      <= lock_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEP:   sep_char_reg   <= cfg_data;
                    CFG_QUOTE: quote_char_reg <= cfg_data;
                    CFG_TRIM:  trim_reg       <= cfg_data[0];
                    CFG_CRLF:  crlf_reg       <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
    end

endmodule

>>> sv/csvfw_queue.sv
// csvfw_queue: short job FIFO between front and back ends.
// Depends on csvfw_pkg.
module csvfw_queue
    import csvfw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    job_t          slot_reg [0:Q_DEPTH-1];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(Q_DEPTH));
    assign pop_job = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

>>> sv/csvfw_back.sv
// csvfw_back: output sequencer; turns jobs into one output word per step,
// owns the field buffer memory and does quote wrapping and doubling.
// Depends on csvfw_pkg.
module csvfw_back
    import csvfw_pkg::*;
#(
    parameter int MAX_FIELD = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  job_t    q_job,
    output logic    pop,
    input  mem_wr_t mem_wr,
    output result_t result,
    output logic    strobe,
    output logic    dump_done
);

    localparam int AW = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEP,
        S_BYTE,
        S_CR,
        S_LF,
        S_OPEN,
        S_FETCH,
        S_DATA,
        S_DOUBLE,
        S_CLOSE
    } state_t;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    result_t          result_reg, result_next;
    logic             strobe_reg, strobe_next;
    logic             done_reg, done_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [0:MAX_FIELD-1];
    logic             at_end;

    function automatic state_t body_entry(input job_t j);
        case (j.body)
            BODY_BYTE: return S_BYTE;
            BODY_EOL:  return j.crlf ? S_CR : S_LF;
            BODY_DUMP: return j.quote ? S_OPEN : S_FETCH;
            default:   return S_IDLE;
        endcase
    endfunction

    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign at_end    = (idx_reg == job_reg.count - CNT_W'(1));
    assign result    = result_reg;
    assign strobe    = strobe_reg;
    assign dump_done = done_reg;

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        result_next = '0;
        strobe_next = 1'b0;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    job_next   = q_job;
                    idx_next   = '0;
                    state_next = q_job.sep ? S_SEP : body_entry(q_job);
                end
            end
            S_SEP:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = job_reg.sep_char;
                result_next.run_last = (job_reg.body == BODY_NONE);
                state_next           = body_entry(job_reg);
            end
            S_BYTE:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = job_reg.data;
                result_next.run_last = 1'b1;
                state_next           = S_IDLE;
            end
            S_CR:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = CH_CR;
                state_next           = S_LF;
            end
            S_LF:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = CH_LF;
                result_next.run_last = 1'b1;
                state_next           = S_IDLE;
            end
            S_OPEN:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = job_reg.quote_char;
                state_next           = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = rd_data_reg;
                if (job_reg.quote && rd_data_reg == job_reg.quote_char)
                begin
                    state_next = S_DOUBLE;
                end
                else if (at_end)
                begin
                    if (job_reg.quote)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        result_next.run_last = 1'b1;
                        done_next            = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_DOUBLE:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = job_reg.quote_char;
                if (at_end)
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_CLOSE:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = job_reg.quote_char;
                result_next.run_last = 1'b1;
                done_next            = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (strobe_next)
        begin
            result_next.overflow = job_reg.ov;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            job_reg    <= '0;
            idx_reg    <= '0;
            result_reg <= '0;
            strobe_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            job_reg    <= job_next;
            idx_reg    <= idx_next;
            result_reg <= result_next;
            strobe_reg <= strobe_next;
            done_reg   <= done_next;
        end
    end

    // field buffer: written by the front end, read one entry per fetch
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
        end
        if (state_reg == S_FETCH)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

endmodule

>>> sv/csv_field_writer_unit.sv
// csv_field_writer_unit: top level of the CSV field writer.
// Depends on csvfw_pkg, csvfw_front, csvfw_queue, csvfw_back.
//
// Usage
//   Command channel: a word on item is taken at a rising edge with start high
//   and busy low. cmd selects quoted-as-needed byte, raw byte or end of row.
//   Result channel: each output byte appears on result for one cycle with
//   strobe high; run_last marks the last byte caused by one command. The
//   receiver cannot stall: every strobed word is consumed as it appears.
//   Config port: cfg_we/cfg_index/cfg_data write separator, quote, trim and
//   CRLF registers; write only while the block is idle.
// Timing
//   Front end takes a command per cycle while the two-entry job queue has
//   room and no buffered field is still being written out. The back end
//   pops each job in its idle state, and result words are registered. A job
//   then emits one word per cycle for separators, raw bytes and row endings;
//   a buffered field fetches then emits each stored byte, adds a word per
//   doubled quote and one each for the wrapping quotes. busy stays high from
//   the closing byte of a buffered field until its last word has gone out.
// Reset
//   rst_n clears row/field state, queue and sequencer and restores register
//   defaults (separator ',', quote '"', trim off, LF endings). No clearing
//   pass: buffer entries are always written before they are read.
module csv_field_writer_unit
    import csvfw_pkg::*;
#(
    parameter int MAX_FIELD = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  item_t      item,
    output logic       busy,
    output logic       strobe,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic    push, pop, q_empty, q_full, dump_done;
    job_t    push_job, pop_job;
    mem_wr_t mem_wr;

    // front: command decode, field state, buffer writes
    csvfw_front #(
        .MAX_FIELD(MAX_FIELD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .job       (push_job),
        .q_full    (q_full),
        .dump_done (dump_done),
        .mem_wr    (mem_wr)
    );

    // decoupling queue
    csvfw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: byte sequencer and field buffer
    csvfw_back #(
        .MAX_FIELD(MAX_FIELD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .mem_wr    (mem_wr),
        .result    (result),
        .strobe    (strobe),
        .dump_done (dump_done)
    );

endmodule

>>> sv/csvfw_checker.sv
// csvfw_checker: port-level assertions for csv_field_writer_unit, with bind.
// Depends on csvfw_pkg and csv_field_writer_unit.
module csvfw_checker
    import csvfw_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    strobe,
    input result_t result
);

    // idle result word carries no flags
    a_quiet_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !strobe |-> (!result.run_last && !result.overflow))
        else $error("flags set without strobe");

    // sequencer returns to idle after a run, leaving a gap
    a_run_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.run_last) |=> !strobe)
        else $error("word directly after end of run");

    // overflow is a per-run attribute
    a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.run_last && result.overflow) |=> (!strobe || result.overflow))
        else $error("overflow changed inside a run");

endmodule

bind csv_field_writer_unit csvfw_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);
